// ===== sv/lbbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbbs_pkg: shared types and constants of the LED bank blink sequencer
// Command kinds, animation modes, register indexes, reset values and the
// event record passed from an animation step unit to the top level.
// ----------------------------------------------------------------------------
package lbbs_pkg;

  // Command kind, carried in the input tuser
  typedef enum logic [3:0] {
    KIND_REFRESH       = 4'd0,
    KIND_ON            = 4'd1,
    KIND_OFF           = 4'd2,
    KIND_ALL_ON        = 4'd3,
    KIND_ALL_OFF       = 4'd4,
    KIND_BLINK_EN      = 4'd5,
    KIND_BLINK_DIS     = 4'd6,
    KIND_ALL_BLINK_EN  = 4'd7,
    KIND_ALL_BLINK_DIS = 4'd8,
    KIND_BLINK_STEP    = 4'd9,
    KIND_ACK_WAKE      = 4'd10,
    KIND_ACK_STANDBY   = 4'd11
  } kind_e;

  // Animation modes of a refresh item
  localparam logic [1:0] MODE_WAKE    = 2'd1;
  localparam logic [1:0] MODE_STANDBY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_DELAY    = 2'd0;
  localparam logic [1:0] CFG_WAKE_ORDER    = 2'd1;
  localparam logic [1:0] CFG_STANDBY_ORDER = 2'd2;

  // Field widths
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned ORDER_W = 24;
  localparam int unsigned TIME_W  = 32;

  // Register reset values
  localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 16'd100;
  localparam logic [ORDER_W-1:0] ORDER_RST      = 24'hFAC688;

  // Eight 3-bit LED indexes, slot 0 in the low bits
  typedef logic [7:0][2:0] order_t;

  // What one animation step does to the LED bank
  typedef struct packed {
    logic              first;    // first active run: clear or fill the bank
    logic              step;     // delay elapsed: touch one LED
    logic              wrap;     // last slot done: clear bank, raise done
    logic [MASK_W-1:0] led_bit;  // one-hot LED of the current slot
  } anim_ev_t;

endpackage

// ===== sv/lbbs_anim.sv =====
// ----------------------------------------------------------------------------
// lbbs_anim: one animation sequence step
// Checks the elapsed time against the step delay, picks the LED of the
// current slot from the order register and advances the slot and timestamp.
// ----------------------------------------------------------------------------
module lbbs_anim #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                         active_i,
  input  logic                         first_pending_i,
  input  logic [$clog2(LED_COUNT)-1:0] slot_i,
  input  logic [lbbs_pkg::TIME_W-1:0]  last_time_i,
  input  logic [lbbs_pkg::TIME_W-1:0]  now_i,
  input  logic [lbbs_pkg::DELAY_W-1:0] delay_i,
  input  logic [lbbs_pkg::ORDER_W-1:0] order_i,
  output lbbs_pkg::anim_ev_t           ev_o,
  output logic [$clog2(LED_COUNT)-1:0] slot_o,
  output logic [lbbs_pkg::TIME_W-1:0]  last_time_o
);
  import lbbs_pkg::*;

  localparam int unsigned SLOT_W = $clog2(LED_COUNT);

  logic [TIME_W-1:0]   elapsed;
  logic [SLOT_W:0]     slot_inc;
  logic [SLOT_W+2:0]   slot_ext;
  order_t              order;
  logic [2:0]          led_idx;

  // Elapsed time wraps modulo 2^32
  assign elapsed  = now_i - last_time_i;
  assign slot_inc = {1'b0, slot_i} + (SLOT_W+1)'(1);

  // Order lookup uses the low three bits of the slot
  assign slot_ext = (SLOT_W+3)'(slot_i);
  assign order    = order_t'(order_i);
  assign led_idx  = order[slot_ext[2:0]];

  assign ev_o.first   = active_i & first_pending_i;
  assign ev_o.step    = active_i & (elapsed >= TIME_W'(delay_i));
  assign ev_o.wrap    = ev_o.step & (slot_inc >= (SLOT_W+1)'(LED_COUNT));
  assign ev_o.led_bit = MASK_W'(1) << led_idx;

  // Advance slot and timestamp; a finished run returns both to zero
  always_comb begin
    slot_o      = slot_i;
    last_time_o = last_time_i;
    if (ev_o.wrap) begin
      slot_o      = '0;
      last_time_o = '0;
    end else if (ev_o.step) begin
      slot_o      = slot_inc[SLOT_W-1:0];
      last_time_o = now_i;
    end
  end

endmodule

// ===== sv/led_bank_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_bank_blink_sequencer: LED bank with blinking and timed animations
// Keeps on and blink masks for eight LEDs, runs wake-up and standby
// sequences on refresh items and reports the pattern and done flags.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: index, mode, time; tuser: kind
// m_axis    out  m_axis_tvalid/tready        tdata: pattern, wake done, standby done
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One command per cycle while the result register is free or being taken;
// its result shows in the cycle after the transfer. The state update and the
// 32-bit elapsed-time compare sit combinationally between state and result registers.
// The result register stalls input only while it is full and not taken.
// Reset loads defaults, clears state, sets first-run marks; no clearing pass.
// ----------------------------------------------------------------------------
module led_bank_blink_sequencer #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [2:0] led_index, [4:3] anim_mode,
                                      // [36:5] time_ms, [39:37] zero
  input  logic [3:0]  s_axis_tuser,   // [3:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] led_pattern, [8] wake_done,
                                      // [9] standby_done, [15:10] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import lbbs_pkg::*;

  localparam int unsigned SLOT_W = $clog2(LED_COUNT);

  // Configuration registers
  logic [DELAY_W-1:0] step_delay_q;
  logic [ORDER_W-1:0] wake_order_q, standby_order_q;

  // Bank and sequence state
  logic [MASK_W-1:0] on_mask_q, on_mask_d;
  logic [MASK_W-1:0] blink_mask_q, blink_mask_d;
  logic              blink_phase_q, blink_phase_d;
  logic [SLOT_W-1:0] wake_slot_q, wake_slot_d, sb_slot_q, sb_slot_d;
  logic [TIME_W-1:0] wake_time_q, wake_time_d, sb_time_q, sb_time_d;
  logic              wake_first_q, wake_first_d, sb_first_q, sb_first_d;
  logic              wake_flag_q, wake_flag_d, sb_flag_q, sb_flag_d;

  // Result register
  logic              m_valid_q;
  logic [MASK_W-1:0] res_pattern_q;
  logic              res_wake_q, res_sb_q;

  logic              s_fire;
  kind_e             kind;
  logic [2:0]        led_index;
  logic [1:0]        anim_mode;
  logic [TIME_W-1:0] time_ms;
  logic [MASK_W-1:0] sel_bit;
  logic              wake_act, sb_act;
  anim_ev_t          wake_ev, sb_ev;
  logic              res_wake_d, res_sb_d;

  // Unpack the input transfer
  assign kind      = kind_e'(s_axis_tuser);
  assign led_index = s_axis_tdata[2:0];
  assign anim_mode = s_axis_tdata[4:3];
  assign time_ms   = s_axis_tdata[36:5];
  assign sel_bit   = MASK_W'(1) << led_index;

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign wake_act = (kind == KIND_REFRESH) && (anim_mode == MODE_WAKE);
  assign sb_act   = (kind == KIND_REFRESH) && (anim_mode == MODE_STANDBY);

  lbbs_anim #(.LED_COUNT(LED_COUNT)) u_wake (
    .active_i        (wake_act),
    .first_pending_i (wake_first_q),
    .slot_i          (wake_slot_q),
    .last_time_i     (wake_time_q),
    .now_i           (time_ms),
    .delay_i         (step_delay_q),
    .order_i         (wake_order_q),
    .ev_o            (wake_ev),
    .slot_o          (wake_slot_d),
    .last_time_o     (wake_time_d)
  );

  lbbs_anim #(.LED_COUNT(LED_COUNT)) u_standby (
    .active_i        (sb_act),
    .first_pending_i (sb_first_q),
    .slot_i          (sb_slot_q),
    .last_time_i     (sb_time_q),
    .now_i           (time_ms),
    .delay_i         (step_delay_q),
    .order_i         (standby_order_q),
    .ev_o            (sb_ev),
    .slot_o          (sb_slot_d),
    .last_time_o     (sb_time_d)
  );

  // Decode the command into the next bank state
  always_comb begin
    on_mask_d     = on_mask_q;
    blink_mask_d  = blink_mask_q;
    blink_phase_d = blink_phase_q;
    wake_first_d  = wake_first_q & ~wake_ev.first;
    sb_first_d    = sb_first_q & ~sb_ev.first;
    wake_flag_d   = wake_flag_q | wake_ev.wrap;
    sb_flag_d     = sb_flag_q | sb_ev.wrap;
    res_wake_d    = wake_flag_q;
    res_sb_d      = sb_flag_q;
    unique case (kind)
      KIND_REFRESH: begin
        if (wake_ev.first) begin
          on_mask_d    = '0;
          blink_mask_d = '0;
        end
        if (sb_ev.first) begin
          on_mask_d = '1;
        end
        if (wake_ev.step) begin
          on_mask_d = on_mask_d | wake_ev.led_bit;
        end
        if (sb_ev.step) begin
          on_mask_d = on_mask_d & ~sb_ev.led_bit;
        end
        if (wake_ev.wrap || sb_ev.wrap) begin
          on_mask_d    = '0;
          blink_mask_d = '0;
        end
        res_wake_d = wake_flag_d;
        res_sb_d   = sb_flag_d;
      end
      KIND_ON:            on_mask_d    = on_mask_q | sel_bit;
      KIND_OFF:           on_mask_d    = on_mask_q & ~sel_bit;
      KIND_ALL_ON:        on_mask_d    = '1;
      KIND_ALL_OFF: begin
        on_mask_d    = '0;
        blink_mask_d = '0;
      end
      KIND_BLINK_EN:      blink_mask_d = blink_mask_q | sel_bit;
      KIND_BLINK_DIS:     blink_mask_d = blink_mask_q & ~sel_bit;
      KIND_ALL_BLINK_EN:  blink_mask_d = '1;
      KIND_ALL_BLINK_DIS: blink_mask_d = '0;
      KIND_BLINK_STEP: begin
        on_mask_d     = blink_phase_q ? (on_mask_q | blink_mask_q)
                                      : (on_mask_q & ~blink_mask_q);
        blink_phase_d = ~blink_phase_q;
      end
      KIND_ACK_WAKE:      wake_flag_d = 1'b0;
      KIND_ACK_STANDBY:   sb_flag_d   = 1'b0;
      default: ;
    endcase
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q    <= STEP_DELAY_RST;
      wake_order_q    <= ORDER_RST;
      standby_order_q <= ORDER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_DELAY:    step_delay_q    <= cfg_data_i[DELAY_W-1:0];
        CFG_WAKE_ORDER:    wake_order_q    <= cfg_data_i;
        CFG_STANDBY_ORDER: standby_order_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Commit state on each accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_mask_q     <= '0;
      blink_mask_q  <= '0;
      blink_phase_q <= 1'b0;
      wake_slot_q   <= '0;
      wake_time_q   <= '0;
      wake_first_q  <= 1'b1;
      wake_flag_q   <= 1'b0;
      sb_slot_q     <= '0;
      sb_time_q     <= '0;
      sb_first_q    <= 1'b1;
      sb_flag_q     <= 1'b0;
    end else if (s_fire) begin
      on_mask_q     <= on_mask_d;
      blink_mask_q  <= blink_mask_d;
      blink_phase_q <= blink_phase_d;
      wake_slot_q   <= wake_slot_d;
      wake_time_q   <= wake_time_d;
      wake_first_q  <= wake_first_d;
      wake_flag_q   <= wake_flag_d;
      sb_slot_q     <= sb_slot_d;
      sb_time_q     <= sb_time_d;
      sb_first_q    <= sb_first_d;
      sb_flag_q     <= sb_flag_d;
    end
  end

  // Result register: load on transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_pattern_q <= on_mask_d;
      res_wake_q    <= res_wake_d;
      res_sb_q      <= res_sb_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, res_sb_q, res_wake_q, res_pattern_q};

`ifndef ASSERT_OFF
  // Slot counters stay inside the bank
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wake_slot_q < SLOT_W'(LED_COUNT - 1) || wake_slot_q == SLOT_W'(LED_COUNT - 1)) &&
    (sb_slot_q < SLOT_W'(LED_COUNT - 1) || sb_slot_q == SLOT_W'(LED_COUNT - 1)))
    else $error("animation slot out of range");

  // The wake first-run mark never comes back once cleared
  a_first_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wake_first_q |=> !wake_first_q)
    else $error("wake first-run mark set again");

  // A finished sequence leaves the bank dark with no blinking
  a_done_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(wake_flag_q) || $rose(sb_flag_q)) |-> (on_mask_q == '0 && blink_mask_q == '0))
    else $error("done flag raised with LEDs still active");

  // An accepted wake acknowledge clears the flag
  a_ack_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && kind == KIND_ACK_WAKE) |=> !wake_flag_q)
    else $error("wake acknowledge did not clear flag");

  // A result is never lost: a new transfer only enters an empty or draining slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten");
`endif

endmodule

// ===== test/led_pattern_checker.sv =====
// ----------------------------------------------------------------------------
// led_pattern_checker: result checker of the LED bank blink sequencer
// Watches the command, result and register write channels and keeps its own
// copy of the LED bank state. Each command transfer queues the result it
// should produce. Each result transfer is compared field by field with the
// oldest queued result. Failures are counted for the top level.
// ----------------------------------------------------------------------------
module led_pattern_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [2:0] led_index, [4:3] anim_mode,
                                      // [36:5] time_ms, [39:37] zero
  input  logic [3:0]  s_axis_tuser,   // [3:0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] led_pattern, [8] wake_done,
                                      // [9] standby_done, [15:10] zero
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import lbbs_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned BANK_SIZE    = 8;

  // One result as it leaves the block, lowest field last
  typedef struct packed {
    logic              standby_done;
    logic              wake_done;
    logic [MASK_W-1:0] pattern;
  } bank_view_t;

  // Register copies
  logic [DELAY_W-1:0] step_delay;
  order_t             wake_order;
  order_t             standby_order;

  // LED bank state
  logic [MASK_W-1:0]  on_mask;
  logic [MASK_W-1:0]  blink_mask;
  logic               blink_phase;
  logic [3:0]         wake_slot;
  logic [TIME_W-1:0]  wake_last;
  logic               wake_first;
  logic               wake_flag;
  logic [3:0]         standby_slot;
  logic [TIME_W-1:0]  standby_last;
  logic               standby_first;
  logic               standby_flag;

  bank_view_t         view_q[$];

  // One-hot LED named by a slot of an order
  function automatic logic [MASK_W-1:0] slot_led(input order_t order,
                                                 input logic [3:0] slot);
    return MASK_W'(1) << order[slot[2:0]];
  endfunction

  // Advance the bank by one command and return the result it shows
  task automatic apply_command(input  logic [3:0]        kind,
                               input  logic [2:0]        led,
                               input  logic [1:0]        mode,
                               input  logic [TIME_W-1:0] now,
                               output bank_view_t        view);
    logic [MASK_W-1:0] led_bit;
    logic [TIME_W-1:0] elapsed;
    led_bit           = MASK_W'(1) << led;
    view.wake_done    = wake_flag;
    view.standby_done = standby_flag;
    case (kind)
      KIND_REFRESH: begin
        if (mode == MODE_WAKE) begin
          // clear the bank only on the very first wake-up run
          if (wake_first) begin
            wake_first = 1'b0;
            on_mask    = '0;
            blink_mask = '0;
          end
          elapsed = now - wake_last;
          if (elapsed >= TIME_W'(step_delay)) begin
            on_mask   |= slot_led(wake_order, wake_slot);
            wake_slot += 4'd1;
            wake_last  = now;
            if (wake_slot >= BANK_SIZE) begin
              wake_slot  = '0;
              wake_last  = '0;
              wake_flag  = 1'b1;
              on_mask    = '0;
              blink_mask = '0;
            end
          end
        end else if (mode == MODE_STANDBY) begin
          // fill the bank only on the very first standby run
          if (standby_first) begin
            standby_first = 1'b0;
            on_mask       = '1;
          end
          elapsed = now - standby_last;
          if (elapsed >= TIME_W'(step_delay)) begin
            on_mask      &= ~slot_led(standby_order, standby_slot);
            standby_slot += 4'd1;
            standby_last  = now;
            if (standby_slot >= BANK_SIZE) begin
              standby_slot = '0;
              standby_last = '0;
              standby_flag = 1'b1;
              on_mask      = '0;
              blink_mask   = '0;
            end
          end
        end
        view.wake_done    = wake_flag;
        view.standby_done = standby_flag;
      end
      KIND_ON:            on_mask |= led_bit;
      KIND_OFF:           on_mask &= ~led_bit;
      KIND_ALL_ON:        on_mask = '1;
      KIND_ALL_OFF: begin
        on_mask    = '0;
        blink_mask = '0;
      end
      KIND_BLINK_EN:      blink_mask |= led_bit;
      KIND_BLINK_DIS:     blink_mask &= ~led_bit;
      KIND_ALL_BLINK_EN:  blink_mask = '1;
      KIND_ALL_BLINK_DIS: blink_mask = '0;
      KIND_BLINK_STEP: begin
        if (blink_phase) begin
          on_mask |= blink_mask;
        end else begin
          on_mask &= ~blink_mask;
        end
        blink_phase = ~blink_phase;
      end
      KIND_ACK_WAKE:      wake_flag = 1'b0;
      KIND_ACK_STANDBY:   standby_flag = 1'b0;
      default: ;
    endcase
    view.pattern = on_mask;
  endtask

  // Track register writes, queue expected results, compare actual ones
  always @(posedge clk_i or negedge rst_ni) begin : watch
    bank_view_t exp_view;
    bank_view_t got_view;
    if (!rst_ni) begin
      step_delay    = STEP_DELAY_RST;
      wake_order    = ORDER_RST;
      standby_order = ORDER_RST;
      on_mask       = '0;
      blink_mask    = '0;
      blink_phase   = 1'b0;
      wake_slot     = '0;
      wake_last     = '0;
      wake_first    = 1'b1;
      wake_flag     = 1'b0;
      standby_slot  = '0;
      standby_last  = '0;
      standby_first = 1'b1;
      standby_flag  = 1'b0;
      view_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_STEP_DELAY:    step_delay = cfg_data_i[DELAY_W-1:0];
          CFG_WAKE_ORDER:    wake_order = cfg_data_i;
          CFG_STANDBY_ORDER: standby_order = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[4:3],
                      s_axis_tdata[36:5], exp_view);
        view_q.push_back(exp_view);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_view = m_axis_tdata[9:0];
        if (view_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT) begin
            $display("%0t: result transfer with nothing pending:", $realtime,
                     " pattern %02h wake %0b standby %0b", got_view.pattern,
                     got_view.wake_done, got_view.standby_done);
          end
        end else begin
          exp_view = view_q.pop_front();
          if (got_view.pattern !== exp_view.pattern ||
              got_view.wake_done !== exp_view.wake_done ||
              got_view.standby_done !== exp_view.standby_done) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: mismatch: pattern exp %02h got %02h,", $realtime,
                       exp_view.pattern, got_view.pattern,
                       " wake exp %0b got %0b,",
                       exp_view.wake_done, got_view.wake_done,
                       " standby exp %0b got %0b",
                       exp_view.standby_done, got_view.standby_done);
            end
          end
        end
      end
      pending_o = view_q.size();
    end
  end

endmodule

// ===== test/tb_led_bank_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_led_bank_blink_sequencer: testbench of the LED bank blink sequencer
// Runs a short directed pass over every command kind and the first-run,
// threshold and time-wrap cases, then random phases under several register
// settings. Random phases mostly replay wake-up and standby sequences with
// advancing time, mixed with acknowledges, mask commands and noise. The
// command side sends in bursts with gaps; the result side stalls on its own
// pattern. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_led_bank_blink_sequencer;
  import lbbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 310;
  localparam int unsigned PHASE_COUNT     = 5;
  localparam logic [1:0]  MODE_IDLE       = 2'd0;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;
  localparam logic [3:0]  KIND_SPARE_LO   = 4'd12;
  localparam logic [3:0]  KIND_SPARE_HI   = 4'd15;

  typedef enum int unsigned {
    READY_FREE,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_style_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [3:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [23:0] cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count   = 0;

  // Sender and animation bookkeeping
  int unsigned        burst_left = 0;
  logic               tx_active  = 1'b0;
  logic [DELAY_W-1:0] delay_ms   = STEP_DELAY_RST;
  logic [TIME_W-1:0]  now_ms     = '0;
  logic [1:0]         anim_mode  = MODE_WAKE;
  int unsigned        anim_left  = 0;

  // Receiver stall pattern
  ready_style_e       ready_style = READY_FREE;
  int unsigned        ready_left  = 0;

  led_bank_blink_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  led_pattern_checker pattern_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result side in stretches of different styles
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_style = ready_style_e'($urandom_range(0, 3));
      ready_left  = $urandom_range(10, 80);
    end
    ready_left--;
    case (ready_style)
      READY_FREE:   m_axis_tready <= 1'b1;
      READY_COIN:   m_axis_tready <= 1'($urandom());
      READY_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:      m_axis_tready <= (ready_left % 5 != 0);
    endcase
  end

  // Send one command; open a new burst after a gap when the last one ran out
  task automatic send_item(input logic [3:0]        kind,
                           input logic [2:0]        led,
                           input logic [1:0]        mode,
                           input logic [TIME_W-1:0] now);
    if (burst_left == 0) begin
      if (tx_active) begin
        s_axis_tvalid <= 1'b0;
      end
      tx_active = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, now, mode, led};
    s_axis_tuser  <= kind;
    tx_active = 1'b1;
    burst_left--;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop the command stream and wait until every result has come back
  task automatic settle();
    if (tx_active) begin
      s_axis_tvalid <= 1'b0;
    end
    tx_active  = 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (index == CFG_STEP_DELAY) begin
      delay_ms = value[DELAY_W-1:0];
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned phase;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every kind, spare kinds and modes, first runs, thresholds
    send_item(KIND_ALL_ON, 3'd0, MODE_IDLE, '0);
    send_item(KIND_BLINK_EN, 3'd0, MODE_IDLE, '0);
    send_item(KIND_BLINK_EN, 3'd7, MODE_IDLE, '0);
    send_item(KIND_BLINK_STEP, 3'd0, MODE_IDLE, '0);
    send_item(KIND_BLINK_STEP, 3'd0, MODE_IDLE, '0);
    send_item(KIND_BLINK_DIS, 3'd7, MODE_IDLE, '0);
    send_item(KIND_ALL_BLINK_EN, 3'd0, MODE_IDLE, '0);
    send_item(KIND_BLINK_STEP, 3'd0, MODE_IDLE, '0);
    send_item(KIND_ALL_BLINK_DIS, 3'd0, MODE_IDLE, '0);
    send_item(KIND_OFF, 3'd0, MODE_IDLE, '0);
    send_item(KIND_OFF, 3'd7, MODE_IDLE, '0);
    send_item(KIND_ON, 3'd7, MODE_IDLE, '0);
    send_item(KIND_ALL_OFF, 3'd0, MODE_IDLE, '0);
    send_item(KIND_SPARE_LO, 3'd7, MODE_UNUSED, '1);
    send_item(KIND_SPARE_HI, 3'd0, MODE_WAKE, '1);
    send_item(KIND_REFRESH, 3'd7, MODE_IDLE, '1);
    send_item(KIND_REFRESH, 3'd0, MODE_UNUSED, 32'd500);
    send_item(KIND_ON, 3'd3, MODE_IDLE, '0);
    // first wake-up run clears the bank; elapsed zero takes no step
    send_item(KIND_REFRESH, 3'd0, MODE_WAKE, 32'd0);
    send_item(KIND_REFRESH, 3'd0, MODE_WAKE, 32'd100);
    send_item(KIND_REFRESH, 3'd0, MODE_WAKE, 32'd199);
    // time jumps to the top of its range, far past the last step time
    send_item(KIND_REFRESH, 3'd0, MODE_WAKE, '1);
    // first standby run fills the bank; one short of the delay
    send_item(KIND_REFRESH, 3'd0, MODE_STANDBY, 32'd99);
    send_item(KIND_REFRESH, 3'd0, MODE_STANDBY, 32'd100);
    send_item(KIND_ACK_WAKE, 3'd0, MODE_IDLE, '0);
    send_item(KIND_ACK_STANDBY, 3'd0, MODE_IDLE, '0);

    for (phase = 1; phase <= PHASE_COUNT; phase++) begin
      settle();
      // Reprogram the registers for this phase
      case (phase)
        1: begin
          write_reg(CFG_STEP_DELAY, 24'd0);
          write_reg(CFG_WAKE_ORDER, 24'($urandom()));
          write_reg(CFG_STANDBY_ORDER, 24'($urandom()));
        end
        2: begin
          write_reg(CFG_WAKE_ORDER, '0);
          write_reg(CFG_STANDBY_ORDER, '1);
          write_reg(CFG_STEP_DELAY, '1);
        end
        3: begin
          write_reg(CFG_STANDBY_ORDER, 24'($urandom()));
          write_reg(CFG_STEP_DELAY, 24'($urandom_range(1, 250)));
          write_reg(CFG_WAKE_ORDER, 24'($urandom()));
        end
        4: begin
          write_reg(CFG_STEP_DELAY, 24'($urandom()));
          write_reg(CFG_WAKE_ORDER, 24'($urandom()));
          write_reg(CFG_STANDBY_ORDER, 24'($urandom()));
        end
        default: begin
          write_reg(CFG_STEP_DELAY, 24'(STEP_DELAY_RST));
          write_reg(CFG_WAKE_ORDER, ORDER_RST);
          write_reg(CFG_STANDBY_ORDER, ORDER_RST);
        end
      endcase

      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // animation refresh: hold one mode for a stretch, advance time
          if (anim_left == 0) begin
            anim_mode = ($urandom_range(0, 1) == 0) ? MODE_WAKE : MODE_STANDBY;
            anim_left = $urandom_range(4, 40);
          end
          anim_left--;
          case ($urandom_range(0, 9))
            0:       now_ms = $urandom();
            1, 2:    now_ms = now_ms + $urandom_range(0, delay_ms);
            default: now_ms = now_ms + delay_ms + $urandom_range(0, 3);
          endcase
          send_item(KIND_REFRESH, 3'($urandom()), anim_mode, now_ms);
        end else if (pick < 68) begin
          send_item(($urandom_range(0, 1) == 0) ? KIND_ACK_WAKE : KIND_ACK_STANDBY,
                    3'($urandom()), 2'($urandom()), $urandom());
        end else if (pick < 90) begin
          send_item(4'($urandom_range(KIND_ON, KIND_BLINK_STEP)), 3'($urandom()),
                    2'($urandom()), $urandom());
        end else begin
          // noise: any kind, mode and time
          send_item(4'($urandom()), 3'($urandom()), 2'($urandom()), $urandom());
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/lbbs_pkg.sv
sv/lbbs_anim.sv
sv/led_bank_blink_sequencer.sv
test/led_pattern_checker.sv
test/tb_led_bank_blink_sequencer.sv
